// File: design/wpp_pkg.sv
package wpp_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] sample;
    logic               slot;
    logic [31:0]        rate_hz;
    logic               stereo_out;
  } result_t;

  typedef struct packed {
    logic        want_stereo;
    logic [15:0] first_channel;
  } cfg_t;

  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic REG_WANT_STEREO   = 1'b0;
  localparam logic REG_FIRST_CHANNEL = 1'b1;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
  localparam logic [15:0] FORMAT_PCM     = 16'd1;
  localparam logic [15:0] BITS_8         = 16'd8;
  localparam logic [15:0] BITS_16        = 16'd16;
  localparam logic [31:0] FMT_SKIP_BYTES = 32'd6;

endpackage

// File: design/wpp_cfg_regs.sv
module wpp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wpp_pkg::AddrWidth-1:0]  paddr,
  input  logic [wpp_pkg::DataWidth-1:0]  pwdata,
  output logic [wpp_pkg::DataWidth-1:0]  prdata,
  output logic                           pready,
  output wpp_pkg::cfg_t                  cfg_o
);

  logic        want_stereo_q;
  logic [15:0] first_channel_q;
  logic        addr_ok;
  logic        wr_en;

  assign pready  = 1'b1;
  assign addr_ok = (paddr[1:0] == 2'b00);
  assign wr_en   = psel && penable && pwrite && addr_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_stereo_q   <= 1'b0;
      first_channel_q <= 16'd0;
    end else if (wr_en) begin
      unique case (paddr[2])
        wpp_pkg::REG_WANT_STEREO:   want_stereo_q   <= pwdata[0];
        wpp_pkg::REG_FIRST_CHANNEL: first_channel_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (addr_ok) begin
      unique case (paddr[2])
        wpp_pkg::REG_WANT_STEREO:   prdata = {31'd0, want_stereo_q};
        wpp_pkg::REG_FIRST_CHANNEL: prdata = {16'd0, first_channel_q};
        default:                    prdata = '0;
      endcase
    end
  end

  assign cfg_o.want_stereo   = want_stereo_q;
  assign cfg_o.first_channel = first_channel_q;

endmodule

// File: design/wpp_parser.sv
module wpp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              sof_i,
  input  wpp_pkg::cfg_t     cfg_i,
  output logic              res_valid_o,
  output wpp_pkg::result_t  res_o
);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RIFF     = 4'd1;
  localparam logic [3:0] PH_RIFFSIZE = 4'd2;
  localparam logic [3:0] PH_WAVE     = 4'd3;
  localparam logic [3:0] PH_FMT      = 4'd4;
  localparam logic [3:0] PH_FMTSIZE  = 4'd5;
  localparam logic [3:0] PH_FORMAT   = 4'd6;
  localparam logic [3:0] PH_CHANNELS = 4'd7;
  localparam logic [3:0] PH_RATE     = 4'd8;
  localparam logic [3:0] PH_FMTSKIP  = 4'd9;
  localparam logic [3:0] PH_BITS     = 4'd10;
  localparam logic [3:0] PH_CHUNK    = 4'd11;
  localparam logic [3:0] PH_LISTSIZE = 4'd12;
  localparam logic [3:0] PH_LISTSKIP = 4'd13;
  localparam logic [3:0] PH_DATASIZE = 4'd14;
  localparam logic [3:0] PH_DATA     = 4'd15;

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  bif_q, bif_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] chan_cnt_q, chan_cnt_d;
  logic        sixteen_q, sixteen_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] chan_idx_q, chan_idx_d;
  logic [7:0]  low_q, low_d;
  logic        two_q, two_d;
  logic        fmt_bad_q, fmt_bad_d;
  logic        list_seen_q, list_seen_d;
  logic [16:0] fb_q, fb_d;

  logic [3:0]  ph;
  logic [1:0]  bif;
  logic        fmt_bad;
  logic        list_seen;
  logic [31:0] new_shift;
  logic        need2;
  logic        field_done;
  logic [31:0] v;
  logic [15:0] smp;
  logic [16:0] idx_next;
  logic        frame_end;
  logic [31:0] rem_dec;
  logic        bad_bits;

  assign ph        = sof_i ? PH_RIFF : phase_q;
  assign bif       = sof_i ? 2'd0 : bif_q;
  assign fmt_bad   = sof_i ? 1'b0 : fmt_bad_q;
  assign list_seen = sof_i ? 1'b0 : list_seen_q;

  assign new_shift  = {byte_i, shift_q[31:8]};
  assign need2      = (ph == PH_FORMAT) || (ph == PH_CHANNELS) || (ph == PH_BITS);
  assign field_done = need2 ? (bif == 2'd1) : (bif == 2'd3);
  assign v          = need2 ? {16'd0, new_shift[31:16]} : new_shift;
  assign smp        = sixteen_q ? {byte_i, low_q} : {~byte_i[7], byte_i[6:0], 8'd0};
  assign idx_next   = {1'b0, chan_idx_q} + 17'd1;
  assign frame_end  = (idx_next >= {1'b0, chan_cnt_q});
  assign rem_dec    = rem_q - 32'd1;
  assign bad_bits   = (v[15:0] != wpp_pkg::BITS_8) && (v[15:0] != wpp_pkg::BITS_16);

  always_comb begin
    phase_d     = phase_q;
    bif_d       = bif_q;
    shift_d     = shift_q;
    chan_cnt_d  = chan_cnt_q;
    sixteen_d   = sixteen_q;
    rate_d      = rate_q;
    skip_d      = skip_q;
    rem_d       = rem_q;
    chan_idx_d  = chan_idx_q;
    low_d       = low_q;
    two_d       = two_q;
    fmt_bad_d   = fmt_bad_q;
    list_seen_d = list_seen_q;
    fb_d        = fb_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      phase_d     = ph;
      bif_d       = bif;
      fmt_bad_d   = fmt_bad;
      list_seen_d = list_seen;
      if (sof_i) begin
        shift_d = '0;
      end

      if (ph == PH_IDLE) begin
        phase_d = PH_IDLE;
      end else if (ph == PH_DATA) begin
        rem_d = rem_dec;
        if (sixteen_q && (bif == 2'd0)) begin
          low_d = byte_i;
          bif_d = 2'd1;
        end else begin
          bif_d = 2'd0;
          if (chan_idx_q == cfg_i.first_channel) begin
            res_valid_o  = 1'b1;
            res_o.kind   = wpp_pkg::KIND_SAMPLE;
            res_o.sample = smp;
          end else if (two_q &&
                       ({1'b0, chan_idx_q} == ({1'b0, cfg_i.first_channel} + 17'd1))) begin
            res_valid_o  = 1'b1;
            res_o.kind   = wpp_pkg::KIND_SAMPLE;
            res_o.sample = smp;
            res_o.slot   = 1'b1;
          end
          chan_idx_d = frame_end ? 16'd0 : idx_next[15:0];
          // A frame is only started when all of its bytes are still to come.
          if (frame_end && (rem_dec < {15'd0, fb_q})) begin
            phase_d = PH_IDLE;
          end
        end
      end else if ((ph == PH_FMTSKIP) || (ph == PH_LISTSKIP)) begin
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) begin
          phase_d = (ph == PH_FMTSKIP) ? PH_BITS : PH_CHUNK;
        end
      end else begin
        shift_d = new_shift;
        if (!field_done) begin
          bif_d = bif + 2'd1;
        end else begin
          bif_d = 2'd0;
          unique case (ph)
            PH_RIFF: begin
              if (v != wpp_pkg::TAG_RIFF) begin
                phase_d     = PH_IDLE;
                res_valid_o = 1'b1;
                res_o.kind  = wpp_pkg::KIND_REJECT;
              end else begin
                phase_d = PH_RIFFSIZE;
              end
            end
            PH_RIFFSIZE: phase_d = PH_WAVE;
            PH_WAVE: begin
              if (v != wpp_pkg::TAG_WAVE) begin
                phase_d     = PH_IDLE;
                res_valid_o = 1'b1;
                res_o.kind  = wpp_pkg::KIND_REJECT;
              end else begin
                phase_d = PH_FMT;
              end
            end
            PH_FMT: begin
              if (v != wpp_pkg::TAG_FMT) begin
                phase_d     = PH_IDLE;
                res_valid_o = 1'b1;
                res_o.kind  = wpp_pkg::KIND_REJECT;
              end else begin
                phase_d = PH_FMTSIZE;
              end
            end
            PH_FMTSIZE: begin
              if (v != wpp_pkg::FMT_CHUNK_SIZE) begin
                fmt_bad_d = 1'b1;
              end
              phase_d = PH_FORMAT;
            end
            PH_FORMAT: begin
              if (v[15:0] != wpp_pkg::FORMAT_PCM) begin
                fmt_bad_d = 1'b1;
              end
              phase_d = PH_CHANNELS;
            end
            PH_CHANNELS: begin
              chan_cnt_d = v[15:0];
              phase_d    = PH_RATE;
            end
            PH_RATE: begin
              rate_d  = v;
              skip_d  = wpp_pkg::FMT_SKIP_BYTES;
              phase_d = PH_FMTSKIP;
            end
            PH_BITS: begin
              if (v[15:0] == wpp_pkg::BITS_8) begin
                sixteen_d = 1'b0;
              end else if (v[15:0] == wpp_pkg::BITS_16) begin
                sixteen_d = 1'b1;
              end
              if (fmt_bad || bad_bits || (chan_cnt_q == 16'd0)) begin
                fmt_bad_d   = 1'b1;
                phase_d     = PH_IDLE;
                res_valid_o = 1'b1;
                res_o.kind  = wpp_pkg::KIND_REJECT;
              end else begin
                phase_d = PH_CHUNK;
              end
            end
            PH_CHUNK: begin
              if ((v == wpp_pkg::TAG_LIST) && !list_seen) begin
                list_seen_d = 1'b1;
                phase_d     = PH_LISTSIZE;
              end else if (v == wpp_pkg::TAG_DATA) begin
                phase_d = PH_DATASIZE;
              end else begin
                phase_d     = PH_IDLE;
                res_valid_o = 1'b1;
                res_o.kind  = wpp_pkg::KIND_REJECT;
              end
            end
            PH_LISTSIZE: begin
              skip_d  = v;
              phase_d = (v == 32'd0) ? PH_CHUNK : PH_LISTSKIP;
            end
            PH_DATASIZE: begin
              fb_d       = sixteen_q ? {chan_cnt_q, 1'b0} : {1'b0, chan_cnt_q};
              rem_d      = v;
              two_d      = cfg_i.want_stereo && (chan_cnt_q > 16'd1);
              chan_idx_d = 16'd0;
              phase_d    = (v >= {15'd0, fb_d}) ? PH_DATA : PH_IDLE;
              res_valid_o      = 1'b1;
              res_o.kind       = wpp_pkg::KIND_ACCEPT;
              res_o.rate_hz    = rate_q;
              res_o.stereo_out = two_d;
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bif_q       <= 2'd0;
      shift_q     <= 32'd0;
      chan_cnt_q  <= 16'd0;
      sixteen_q   <= 1'b0;
      rate_q      <= 32'd0;
      skip_q      <= 32'd0;
      rem_q       <= 32'd0;
      chan_idx_q  <= 16'd0;
      low_q       <= 8'd0;
      two_q       <= 1'b0;
      fmt_bad_q   <= 1'b0;
      list_seen_q <= 1'b0;
      fb_q        <= 17'd0;
    end else begin
      phase_q     <= phase_d;
      bif_q       <= bif_d;
      shift_q     <= shift_d;
      chan_cnt_q  <= chan_cnt_d;
      sixteen_q   <= sixteen_d;
      rate_q      <= rate_d;
      skip_q      <= skip_d;
      rem_q       <= rem_d;
      chan_idx_q  <= chan_idx_d;
      low_q       <= low_d;
      two_q       <= two_d;
      fmt_bad_q   <= fmt_bad_d;
      list_seen_q <= list_seen_d;
      fb_q        <= fb_d;
    end
  end

  a_data_has_channels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (chan_cnt_q != 16'd0))
    else $error("Data phase entered with no channels.");

  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (rem_q != 32'd0))
    else $error("Data phase held with no bytes remaining.");

  a_result_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> step_i)
    else $error("Result raised without a word being processed.");

endmodule

// File: design/wav_pcm_stream_parser.sv
// Parses a RIFF/WAVE PCM file presented one byte per word and emits a header result
// followed by Q1.15 samples of the selected channels. One byte is taken in every
// cycle unless the output stalls: each word passes from an input register through the
// parser step into a result register, and the throughput of one word per cycle while
// the output does not stall is set by the single parser step between them.

module wav_pcm_stream_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     in_data_byte_i,
  input  logic                           in_start_of_file_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     out_kind_o,
  output logic signed [15:0]             out_sample_o,
  output logic                           out_slot_o,
  output logic [31:0]                    out_rate_hz_o,
  output logic                           out_stereo_out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wpp_pkg::AddrWidth-1:0]  paddr,
  input  logic [wpp_pkg::DataWidth-1:0]  pwdata,
  output logic [wpp_pkg::DataWidth-1:0]  prdata,
  output logic                           pready
);

  wpp_pkg::cfg_t    cfg;
  wpp_pkg::result_t res;
  wpp_pkg::result_t out_q;
  logic             res_valid;
  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_sof_q;
  logic             out_valid_q;
  logic             out_free;
  logic             advance;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !advance;

  wpp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wpp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .sof_i       (in_sof_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= in_data_byte_i;
      in_sof_q  <= in_start_of_file_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = out_q.kind;
  assign out_sample_o     = out_q.sample;
  assign out_slot_o       = out_q.slot;
  assign out_rate_hz_o    = out_q.rate_hz;
  assign out_stereo_out_o = out_q.stereo_out;

  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_kind_o == wpp_pkg::KIND_SAMPLE) ||
                    (out_kind_o == wpp_pkg::KIND_ACCEPT) ||
                    (out_kind_o == wpp_pkg::KIND_REJECT))
    else $error("Result word carries an unknown kind.");

  a_header_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o != wpp_pkg::KIND_SAMPLE)) |->
      ((out_sample_o == 16'sd0) && (out_slot_o == 1'b0)))
    else $error("Header result word carries sample fields.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("Input stalled while the result register could move.");

endmodule
